### sv/fmir_pkg.sv
// Package for the forward-map image rotator: sizes, widths, register
// indexes and the pixel type shared by the interfaces and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package fmir_pkg;

   // Design sizes.
   localparam int MAX_SRC_SIDE  = 4096;
   localparam int MAX_DEST_SIDE = 8192;
   localparam int FRAC_BITS     = 14;

   // Fixed field and register widths.
   localparam int PIX_W     = 8;
   localparam int ADDR_W    = 26;
   localparam int COEF_W    = 16;
   localparam int SHIFT_W   = 15;
   localparam int DREG_W    = 14;
   localparam int SREG_W    = 13;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   // Derived widths.
   localparam int CNT_W   = $clog2(MAX_SRC_SIDE);      // source column or row
   localparam int SSIZE_W = CNT_W + 1;                 // source size 1..MAX
   localparam int DPOS_W  = $clog2(MAX_DEST_SIDE);     // output column or row
   localparam int DSIZE_W = DPOS_W + 1;                // output size 1..MAX
   localparam int PROD_W  = CNT_W + 1 + COEF_W;        // coordinate times Q1.x
   localparam int SHF_W   = SHIFT_W + FRAC_BITS;       // scaled offset
   localparam int ACC_W   = ((PROD_W > SHF_W) ? PROD_W : SHF_W) + 2;
   localparam int ROW_W   = DPOS_W + DSIZE_W;          // row times pitch
   localparam int TOT_W   = 2 * DSIZE_W;               // buffer size

   localparam logic [COEF_W-1:0] COS_RESET = 16'h4000;  // 1.0 in Q1.14

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COS_ANGLE   = 3'd0,
      REG_SIN_ANGLE   = 3'd1,
      REG_SHIFT_X     = 3'd2,
      REG_SHIFT_Y     = 3'd3,
      REG_DEST_WIDTH  = 3'd4,
      REG_DEST_HEIGHT = 3'd5,
      REG_SRC_WIDTH   = 3'd6,
      REG_SRC_HEIGHT  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } pix_type;

endpackage

### sv/fmir_if.sv
// Valid/ready channel interfaces of the forward-map image rotator:
// raw pixels in, output buffer writes out. Depends on fmir_pkg.
`timescale 1ns / 1ps

interface fmir_req_if import fmir_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red_in;
   logic [PIX_W-1:0] green_in;
   logic [PIX_W-1:0] blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface fmir_rsp_if import fmir_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] write_address;
   logic [PIX_W-1:0]  red_out;
   logic [PIX_W-1:0]  green_out;
   logic [PIX_W-1:0]  blue_out;
   logic              alpha_out;
   logic              last_write;

   modport source (output valid, write_address, red_out, green_out, blue_out,
                   alpha_out, last_write, input ready);
   modport sink   (input valid, write_address, red_out, green_out, blue_out,
                   alpha_out, last_write, output ready);
endinterface

### sv/forward_map_image_rotator.sv
// Forward-map nearest-neighbor image rotator, top level.
// Depends on fmir_pkg and the channel interfaces in fmir_if.sv.
`timescale 1ns / 1ps

// Usage:
// Raw RGB pixels enter on req_chan in raster order; an internal column and
// row counter gives each pixel its source position. The position is rotated
// with the cosine and sine registers, offset, floored and clamped into the
// output image. Each pixel gives one write on rsp_chan at row*width+column
// and a second write of the same color at the next address, unless that
// address lies past the end of the buffer; last_write marks the final one.
// Registers are written through csr_wr_en/csr_index/csr_wdata and must only
// change while no pixel is in flight.
// An accepted pixel passes stages s1 to s4 and then the output register,
// which shows its first write. Throughput is set by the single result port:
// a pixel that makes both writes holds the port for both of them, one with
// a single write for that write only. Pixels keep flowing into the
// four-stage pipeline while a write waits in the output register. When the
// receiver stalls, the output register holds and the pipeline fills, after which req_chan.ready drops.
// Synchronous reset empties the pipeline, zeroes the counters and loads
// the register reset values (identity rotation, 1x1 images).
module forward_map_image_rotator import fmir_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   fmir_req_if.sink             req_chan,
   fmir_rsp_if.source           rsp_chan
);

   // Configuration registers.
   logic [COEF_W-1:0]  cos_ff, sin_ff;
   logic [SHIFT_W-1:0] shift_x_ff, shift_y_ff;
   logic [DREG_W-1:0]  dest_width_ff, dest_height_ff;
   logic [SREG_W-1:0]  src_width_ff, src_height_ff;
   logic [TOT_W-1:0]   total_ff;

   logic [DSIZE_W-1:0] dw_sat, dh_sat;
   logic [SSIZE_W-1:0] sw_sat, sh_sat;

   // Source position counters.
   logic [CNT_W-1:0] col_ff, col_in, row_ff, row_in;

   // Pipeline stages.
   logic                    s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, o_v_ff;
   logic [CNT_W-1:0]        s1_x_ff, s1_y_ff;
   pix_type                 s1_pix_ff, s2_pix_ff, s3_pix_ff, s4_pix_ff, o_pix_ff;
   logic signed [ACC_W-1:0] s2_fx_ff, s2_fy_ff, s2_fx_in, s2_fy_in;
   logic [DPOS_W-1:0]       s3_px_ff, s3_py_ff, s4_px_ff;
   logic [ROW_W-1:0]        s4_row_ff;
   logic [ADDR_W-1:0]       o_addr_ff;
   logic                    o_second_ff, o_phase_ff;

   logic                     s1_free, s2_free, s3_free, s4_free, o_free, o_last;
   logic                     req_fire;
   logic signed [CNT_W:0]    xs, ys;
   logic signed [PROD_W-1:0] xc, ys_p, xs_p, yc;
   logic signed [ACC_W-1:0]  flx, fly;
   logic [ROW_W-1:0]         addr_sum;
   logic                     second_in;

   function automatic logic [DPOS_W-1:0] clamp_pos(input logic signed [ACC_W-1:0] v,
                                                   input logic [DSIZE_W-1:0] size);
      logic [DPOS_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v >= $signed(ACC_W'(size))) begin
         r = DPOS_W'(size - 1'b1);
      end else begin
         r = DPOS_W'(v);
      end
      return r;
   endfunction

   // Sizes saturated into their legal ranges.
   always_comb begin
      dw_sat = (dest_width_ff == '0) ? DSIZE_W'(1)
             : (dest_width_ff > DREG_W'(MAX_DEST_SIDE)) ? DSIZE_W'(MAX_DEST_SIDE)
             : DSIZE_W'(dest_width_ff);
      dh_sat = (dest_height_ff == '0) ? DSIZE_W'(1)
             : (dest_height_ff > DREG_W'(MAX_DEST_SIDE)) ? DSIZE_W'(MAX_DEST_SIDE)
             : DSIZE_W'(dest_height_ff);
      sw_sat = (src_width_ff == '0) ? SSIZE_W'(1)
             : (src_width_ff > SREG_W'(MAX_SRC_SIDE)) ? SSIZE_W'(MAX_SRC_SIDE)
             : SSIZE_W'(src_width_ff);
      sh_sat = (src_height_ff == '0) ? SSIZE_W'(1)
             : (src_height_ff > SREG_W'(MAX_SRC_SIDE)) ? SSIZE_W'(MAX_SRC_SIDE)
             : SSIZE_W'(src_height_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff         <= COS_RESET;
         sin_ff         <= '0;
         shift_x_ff     <= '0;
         shift_y_ff     <= '0;
         dest_width_ff  <= DREG_W'(1);
         dest_height_ff <= DREG_W'(1);
         src_width_ff   <= SREG_W'(1);
         src_height_ff  <= SREG_W'(1);
         total_ff       <= TOT_W'(1);
      end else begin
         total_ff <= dw_sat * dh_sat;
         if (csr_wr_en) begin
            unique case (reg_index_type'(csr_index))
               REG_COS_ANGLE:   cos_ff         <= csr_wdata[COEF_W-1:0];
               REG_SIN_ANGLE:   sin_ff         <= csr_wdata[COEF_W-1:0];
               REG_SHIFT_X:     shift_x_ff     <= csr_wdata[SHIFT_W-1:0];
               REG_SHIFT_Y:     shift_y_ff     <= csr_wdata[SHIFT_W-1:0];
               REG_DEST_WIDTH:  dest_width_ff  <= csr_wdata[DREG_W-1:0];
               REG_DEST_HEIGHT: dest_height_ff <= csr_wdata[DREG_W-1:0];
               REG_SRC_WIDTH:   src_width_ff   <= csr_wdata[SREG_W-1:0];
               REG_SRC_HEIGHT:  src_height_ff  <= csr_wdata[SREG_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Backpressure: a stage takes new data when it is empty or its item moves on.
   always_comb begin
      o_last   = o_phase_ff || !o_second_ff;
      o_free   = !o_v_ff || (rsp_chan.ready && o_last);
      s4_free  = !s4_v_ff || o_free;
      s3_free  = !s3_v_ff || s4_free;
      s2_free  = !s2_v_ff || s3_free;
      s1_free  = !s1_v_ff || s2_free;
      req_fire = req_chan.valid && s1_free;
   end

   assign req_chan.ready = s1_free;

   // Raster counters advance on every accepted item.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if ((SSIZE_W'(col_ff) + 1'b1) >= sw_sat) begin
            col_in = '0;
            if ((SSIZE_W'(row_ff) + 1'b1) >= sh_sat) begin
               row_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // Rotation in fixed point.
   always_comb begin
      xs       = $signed({1'b0, s1_x_ff});
      ys       = $signed({1'b0, s1_y_ff});
      xc       = xs * $signed(cos_ff);
      ys_p     = ys * $signed(sin_ff);
      xs_p     = xs * $signed(sin_ff);
      yc       = ys * $signed(cos_ff);
      s2_fx_in = ACC_W'(xc) - ACC_W'(ys_p)
               + (ACC_W'($signed(shift_x_ff)) <<< FRAC_BITS);
      s2_fy_in = ACC_W'(xs_p) + ACC_W'(yc)
               + (ACC_W'($signed(shift_y_ff)) <<< FRAC_BITS);
      // Arithmetic shift floors toward minus infinity.
      flx      = s2_fx_ff >>> FRAC_BITS;
      fly      = s2_fy_ff >>> FRAC_BITS;
      addr_sum = s4_row_ff + ROW_W'(s4_px_ff);
      second_in = (TOT_W'(addr_sum) + 1'b1) < total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         s3_v_ff    <= 1'b0;
         s4_v_ff    <= 1'b0;
         o_v_ff     <= 1'b0;
         o_phase_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (s1_free) begin
            s1_v_ff <= req_chan.valid;
         end
         if (s2_free) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_free) begin
            s3_v_ff <= s2_v_ff;
         end
         if (s4_free) begin
            s4_v_ff <= s3_v_ff;
         end
         if (o_free) begin
            o_v_ff     <= s4_v_ff;
            o_phase_ff <= 1'b0;
         end else if (rsp_chan.ready) begin
            o_phase_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_x_ff   <= col_ff;
         s1_y_ff   <= row_ff;
         s1_pix_ff <= '{red: req_chan.red_in, green: req_chan.green_in,
                        blue: req_chan.blue_in};
      end
      if (s2_free) begin
         s2_fx_ff  <= s2_fx_in;
         s2_fy_ff  <= s2_fy_in;
         s2_pix_ff <= s1_pix_ff;
      end
      if (s3_free) begin
         s3_px_ff  <= clamp_pos(flx, dw_sat);
         s3_py_ff  <= clamp_pos(fly, dh_sat);
         s3_pix_ff <= s2_pix_ff;
      end
      if (s4_free) begin
         s4_row_ff <= s3_py_ff * dw_sat;
         s4_px_ff  <= s3_px_ff;
         s4_pix_ff <= s3_pix_ff;
      end
      if (o_free) begin
         o_addr_ff   <= ADDR_W'(addr_sum);
         o_second_ff <= second_in;
         o_pix_ff    <= s4_pix_ff;
      end
   end

   assign rsp_chan.valid         = o_v_ff;
   assign rsp_chan.write_address = o_addr_ff + ADDR_W'(o_phase_ff);
   assign rsp_chan.red_out       = o_pix_ff.red;
   assign rsp_chan.green_out     = o_pix_ff.green;
   assign rsp_chan.blue_out      = o_pix_ff.blue;
   assign rsp_chan.alpha_out     = 1'b1;
   assign rsp_chan.last_write    = o_last;

   // A first write that is not the last is followed at once by the second
   // write of the same item at the next address.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last_write |=>
         rsp_chan.valid && rsp_chan.last_write &&
         rsp_chan.write_address == $past(rsp_chan.write_address) + ADDR_W'(1))
      else $error("second write of an item did not follow its first write");

   // The second write is only shown for items that have one.
   a_phase_second: assert property (@(posedge clock) disable iff (reset)
      o_phase_ff |-> o_v_ff && o_second_ff)
      else $error("second write phase without a pending second write");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && !o_phase_ff)
      else $error("output still valid after reset");

endmodule

### bench/forward_map_image_rotator_tb.sv
// Testbench for forward_map_image_rotator: pixels go in on the request channel.
// Each buffer write that comes back is checked against an in-bench rotation model.
// Depends on fmir_pkg, the channel interfaces in fmir_if.sv and the top level.
`timescale 1ns / 1ps

module forward_map_image_rotator_tb import fmir_pkg::*; ;

   localparam int RESULT_LATENCY = 6;
   localparam int RANDOM_PIXELS  = 1200;

   typedef struct {
      logic [ADDR_W-1:0] addr;
      pix_type           color;
      logic              last;
   } buf_write_type;

   logic clock = 1'b0;
   logic reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   fmir_req_if req_chan ();
   fmir_rsp_if rsp_chan ();

   forward_map_image_rotator uut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rotation model state: register copies and the source raster position.
   logic [CSR_W-1:0] cfg_regs [8];
   longint           src_col;
   longint           src_row;
   buf_write_type    pending_writes [$];

   int  pixels_accepted;
   int  writes_checked;
   int  single_write_pixels;
   int  settings_applied;
   int  mismatches;
   bit  gaps_enable;
   bit  stall_enable;
   int  stall_left;

   function automatic int reg_bits(input reg_index_type idx);
      unique case (idx)
         REG_COS_ANGLE, REG_SIN_ANGLE:   return COEF_W;
         REG_SHIFT_X, REG_SHIFT_Y:       return SHIFT_W;
         REG_DEST_WIDTH, REG_DEST_HEIGHT: return DREG_W;
         default:                        return SREG_W;
      endcase
   endfunction

   function automatic longint saturate_side(input longint v, input longint maxv);
      if (v < 1) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic longint clamp_into(input longint v, input longint side);
      if (v < 0) return 0;
      if (v >= side) return side - 1;
      return v;
   endfunction

   // Mostly short pauses, now and then a long one.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   task automatic reset_model();
      cfg_regs[REG_COS_ANGLE]   = CSR_W'(COS_RESET);
      cfg_regs[REG_SIN_ANGLE]   = '0;
      cfg_regs[REG_SHIFT_X]     = '0;
      cfg_regs[REG_SHIFT_Y]     = '0;
      cfg_regs[REG_DEST_WIDTH]  = CSR_W'(1);
      cfg_regs[REG_DEST_HEIGHT] = CSR_W'(1);
      cfg_regs[REG_SRC_WIDTH]   = CSR_W'(1);
      cfg_regs[REG_SRC_HEIGHT]  = CSR_W'(1);
      src_col = 0;
      src_row = 0;
   endtask

   // Works out the buffer writes one pixel causes and advances the raster.
   task automatic predict_writes(input pix_type color);
      longint        cos_v, sin_v, sx, sy, one, fx, fy;
      longint        dw, dh, sw, sh, px, py, addr, total;
      buf_write_type w;
      cos_v = longint'($signed(cfg_regs[REG_COS_ANGLE]));
      sin_v = longint'($signed(cfg_regs[REG_SIN_ANGLE]));
      sx    = longint'($signed(cfg_regs[REG_SHIFT_X][SHIFT_W-1:0]));
      sy    = longint'($signed(cfg_regs[REG_SHIFT_Y][SHIFT_W-1:0]));
      dw    = saturate_side(longint'(cfg_regs[REG_DEST_WIDTH][DREG_W-1:0]), MAX_DEST_SIDE);
      dh    = saturate_side(longint'(cfg_regs[REG_DEST_HEIGHT][DREG_W-1:0]), MAX_DEST_SIDE);
      sw    = saturate_side(longint'(cfg_regs[REG_SRC_WIDTH][SREG_W-1:0]), MAX_SRC_SIDE);
      sh    = saturate_side(longint'(cfg_regs[REG_SRC_HEIGHT][SREG_W-1:0]), MAX_SRC_SIDE);
      one   = longint'(1) << FRAC_BITS;
      fx    = src_col * cos_v - src_row * sin_v + sx * one;
      fy    = src_col * sin_v + src_row * cos_v + sy * one;
      // An arithmetic shift of a signed value floors toward minus infinity.
      px    = clamp_into(fx >>> FRAC_BITS, dw);
      py    = clamp_into(fy >>> FRAC_BITS, dh);
      addr  = py * dw + px;
      total = dw * dh;
      w.color = color;
      w.addr  = addr[ADDR_W-1:0];
      w.last  = !(addr + 1 < total);
      pending_writes.push_back(w);
      if (addr + 1 < total) begin
         addr   = addr + 1;
         w.addr = addr[ADDR_W-1:0];
         w.last = 1'b1;
         pending_writes.push_back(w);
      end else begin
         single_write_pixels++;
      end
      if (src_col + 1 >= sw) begin
         src_col = 0;
         src_row = (src_row + 1 >= sh) ? 0 : src_row + 1;
      end else begin
         src_col = src_col + 1;
      end
   endtask

   task automatic check_write(input buf_write_type w);
      if (rsp_chan.write_address !== w.addr) begin
         $error("write_address: expected %0d, got %0d", w.addr, rsp_chan.write_address);
         mismatches++;
      end
      if (rsp_chan.red_out !== w.color.red) begin
         $error("red_out: expected %0d, got %0d", w.color.red, rsp_chan.red_out);
         mismatches++;
      end
      if (rsp_chan.green_out !== w.color.green) begin
         $error("green_out: expected %0d, got %0d", w.color.green, rsp_chan.green_out);
         mismatches++;
      end
      if (rsp_chan.blue_out !== w.color.blue) begin
         $error("blue_out: expected %0d, got %0d", w.color.blue, rsp_chan.blue_out);
         mismatches++;
      end
      if (rsp_chan.alpha_out !== 1'b1) begin
         $error("alpha_out: expected 1, got %0b", rsp_chan.alpha_out);
         mismatches++;
      end
      if (rsp_chan.last_write !== w.last) begin
         $error("last_write: expected %0b, got %0b", w.last, rsp_chan.last_write);
         mismatches++;
      end
   endtask

   // Both channels are watched in one process so a prediction is always in
   // place before the write it describes is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predict_writes({req_chan.red_in, req_chan.green_in, req_chan.blue_in});
            pixels_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_writes.size() == 0) begin
               $error("write_address %0d arrived with no write expected",
                      rsp_chan.write_address);
               mismatches++;
            end else begin
               check_write(pending_writes.pop_front());
            end
            writes_checked++;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_enable && $urandom_range(0, 99) < 25) begin
         stall_left = pick_pause() - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic send_pixel(input pix_type color);
      int gap;
      gap = (gaps_enable && $urandom_range(0, 99) < 30) ? pick_pause() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.red_in   <= color.red;
      req_chan.green_in <= color.green;
      req_chan.blue_in  <= color.blue;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic pix_type random_color();
      return pix_type'(24'($urandom_range(0, 24'hFFFFFF)));
   endfunction

   // Stops the sender and waits until every predicted write has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (RESULT_LATENCY) @(negedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [CSR_W-1:0] value);
      int mask;
      mask = (1 << reg_bits(idx)) - 1;
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      cfg_regs[idx] = value & CSR_W'(mask);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_settings(input int cos_v, input int sin_v, input int sx, input int sy,
                                 input int dw, input int dh, input int sw, input int sh);
      csr_write(REG_COS_ANGLE, CSR_W'(cos_v));
      csr_write(REG_SIN_ANGLE, CSR_W'(sin_v));
      csr_write(REG_SHIFT_X, CSR_W'(sx));
      csr_write(REG_SHIFT_Y, CSR_W'(sy));
      csr_write(REG_DEST_WIDTH, CSR_W'(dw));
      csr_write(REG_DEST_HEIGHT, CSR_W'(dh));
      csr_write(REG_SRC_WIDTH, CSR_W'(sw));
      csr_write(REG_SRC_HEIGHT, CSR_W'(sh));
      settings_applied++;
   endtask

   // With reset values both images are 1x1, so every pixel makes one write.
   task automatic test_reset_values();
      send_pixel('{8'h00, 8'h00, 8'h00});
      send_pixel('{8'hFF, 8'hFF, 8'hFF});
      send_pixel('{8'hAA, 8'h55, 8'hAA});
      wait_drained();
   endtask

   // Half turn into a 2x2 buffer: the right edge clamps, and the pixel that
   // lands on the last address drops its second write.
   task automatic test_half_turn_clamping();
      write_settings(-16384, 0, 2, 1, 2, 2, 3, 2);
      repeat (6) send_pixel(random_color());
      wait_drained();
   endtask

   // 45 degree turn with a negative offset: negative fractions must floor,
   // and positions left of the image clamp to column 0. The frame is left
   // unfinished so the next test shrinks the source under the counters.
   task automatic test_oblique_floor();
      write_settings(11585, 11585, -1, 0, 4, 3, 4, 2);
      repeat (6) send_pixel(random_color());
      wait_drained();
   endtask

   // Zero and oversized sizes saturate; coefficients and shifts take the
   // raw extremes of their register widths.
   task automatic test_size_saturation();
      write_settings(16'h7FFF, 16'h8000, 15'h3FFF, 15'h4000, 0, 16383, 0, 8191);
      repeat (3) send_pixel(random_color());
      wait_drained();
   endtask

   function automatic int pick_coef();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return int'($urandom_range(0, 32768)) - 16384;
      if (r < 85) return (int'($urandom_range(0, 2)) - 1) * 16384;
      return $urandom_range(0, 65535);
   endfunction

   function automatic int pick_shift();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return int'($urandom_range(0, 64)) - 16;
      if (r < 85) return int'($urandom_range(0, 16384)) - 8192;
      if (r < 95) return $urandom_range(0, 1) ? 8192 : -8192;
      return $urandom_range(0, 65535);
   endfunction

   function automatic int pick_side(input int common_max, input int side_max,
                                    input int reg_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, common_max);
      if (r < 90) return side_max;
      if (r < 95) return $urandom_range(0, 1) ? 0 : $urandom_range(side_max + 1, reg_max);
      return $urandom_range(1, side_max);
   endfunction

   // Phases of random pixels, each under fresh settings and its own mix of
   // sender gaps and receiver stalls; the raster carries over between phases.
   task automatic test_random_frames();
      int sent;
      int phase_len;
      int pause_at;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         write_settings(pick_coef(), pick_coef(), pick_shift(), pick_shift(),
                        pick_side(48, MAX_DEST_SIDE, 16383),
                        pick_side(48, MAX_DEST_SIDE, 16383),
                        pick_side(12, MAX_SRC_SIDE, 8191),
                        pick_side(12, MAX_SRC_SIDE, 8191));
         gaps_enable  = $urandom_range(0, 1);
         stall_enable = $urandom_range(0, 1);
         phase_len    = $urandom_range(40, 140);
         pause_at     = ($urandom_range(0, 2) == 0) ? $urandom_range(1, phase_len - 1) : -1;
         for (int i = 0; i < phase_len; i++) begin
            if (i == pause_at) wait_drained();
            send_pixel(random_color());
         end
         sent += phase_len;
         wait_drained();
      end
      gaps_enable  = 1'b0;
      stall_enable = 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int waited;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = REG_COS_ANGLE;
      csr_wdata         = '0;
      req_chan.valid    = 1'b0;
      req_chan.red_in   = '0;
      req_chan.green_in = '0;
      req_chan.blue_in  = '0;
      rsp_chan.ready    = 1'b0;
      gaps_enable       = 1'b0;
      stall_enable      = 1'b0;
      stall_left        = 0;
      pixels_accepted   = 0;
      writes_checked    = 0;
      single_write_pixels = 0;
      settings_applied  = 0;
      mismatches        = 0;
      reset_model();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_half_turn_clamping();
      test_oblique_floor();
      test_size_saturation();
      test_random_frames();

      @(negedge clock);
      req_chan.valid <= 1'b0;
      waited = 0;
      while (pending_writes.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      if (pending_writes.size() != 0) begin
         $error("%0d expected writes never arrived", pending_writes.size());
         mismatches++;
      end
      repeat (RESULT_LATENCY) @(negedge clock);

      $display("Run covered %0d pixels under %0d register settings, giving %0d writes.",
               pixels_accepted, settings_applied, writes_checked);
      $display("%0d pixels had their second write dropped at the buffer end.",
               single_write_pixels);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
